[src/smeu_pkg.sv]
package smeu_pkg;

  localparam int StackDepth = 64;
  localparam int StoreDepth = 256;
  localparam int WordBits   = 64;
  localparam int SpW        = $clog2(StackDepth + 1);
  localparam int SaW        = $clog2(StackDepth);
  localparam int AdW        = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  typedef enum logic [4:0] {
    C_LIT = 5'd0, C_ADD = 5'd1, C_SUB = 5'd2, C_MUL = 5'd3, C_DIV = 5'd4,
    C_AND = 5'd5, C_OR = 5'd6, C_XOR = 5'd7, C_NOT = 5'd8, C_SHL = 5'd9,
    C_SHR = 5'd10, C_LAND = 5'd11, C_LOR = 5'd12, C_GT = 5'd13, C_LT = 5'd14,
    C_EQ = 5'd15, C_NE = 5'd16, C_LE = 5'd17, C_GE = 5'd18, C_LNOT = 5'd19,
    C_EXIT = 5'd20, C_DROP = 5'd21, C_DUP = 5'd22, C_SWAP = 5'd23,
    C_OVER = 5'd24, C_ROT = 5'd25, C_NIP = 5'd26, C_TUCK = 5'd27,
    C_DROP2 = 5'd28, C_DUP2 = 5'd29, C_STORE = 5'd30, C_FETCH = 5'd31
  } cmd_t;

  typedef enum logic [2:0] {
    E_OK = 3'd0, E_UNDER = 3'd1, E_OVER = 3'd2, E_DIVZ = 3'd3,
    E_NEGSH = 3'd4, E_BIGSH = 3'd5, E_ADDR = 3'd6, E_HALT = 3'd7
  } err_t;

  typedef struct packed {
    logic [4:0]         cmd;
    logic signed [63:0] literal;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] top_value;
    logic [6:0]         stack_depth;
    logic [2:0]         error_code;
    logic               halted;
  } out_word_t;

  // shared unit operation select
  typedef enum logic [1:0] {
    U_MUL = 2'd0, U_DIV = 2'd1, U_SHL = 2'd2, U_SHR = 2'd3
  } uop_t;

  typedef struct packed {
    logic       start;
    uop_t       op;
  } unit_ctl_t;

endpackage

[src/smeu_alu_unit.sv]
module smeu_alu_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smeu_pkg::unit_ctl_t   ctl,
  input  logic [63:0]           a,
  input  logic [63:0]           b,
  output logic                  done,
  output logic [63:0]           result
);
  import smeu_pkg::*;

  // one bit per cycle: shift-add multiply, restoring divide, one-place shifts
  uop_t        op_r;
  logic        busy_r, neg_q_r;
  logic [6:0]  cnt_r;
  logic [63:0] acc_r, opa_r, opb_r, rem_r;
  logic [64:0] diff;
  logic [63:0] rem_sh;
  logic [63:0] absa, absb;

  assign absa   = a[63] ? (64'd0 - a) : a;
  assign absb   = b[63] ? (64'd0 - b) : b;
  assign rem_sh = {rem_r[62:0], opa_r[63]};
  assign diff   = {1'b0, rem_sh} - {1'b0, opb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy_r  <= 1'b1;
        op_r    <= ctl.op;
        neg_q_r <= a[63] ^ b[63];
        rem_r   <= '0;
        case (ctl.op)
          U_MUL: begin acc_r <= '0; opa_r <= a; opb_r <= b; cnt_r <= 7'd64; end
          U_DIV: begin acc_r <= '0; opa_r <= absa; opb_r <= absb; cnt_r <= 7'd64; end
          default: begin acc_r <= a; opa_r <= a; opb_r <= b; cnt_r <= {1'b0, b[5:0]}; end
        endcase
      end else if (busy_r) begin
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
          if (op_r == U_DIV) begin
            acc_r <= neg_q_r ? (64'd0 - acc_r) : acc_r;
          end
        end else begin
          cnt_r <= cnt_r - 7'd1;
          case (op_r)
            U_MUL: begin
              if (opb_r[0]) acc_r <= acc_r + opa_r;
              opa_r <= {opa_r[62:0], 1'b0};
              opb_r <= {1'b0, opb_r[63:1]};
            end
            U_DIV: begin
              opa_r <= {opa_r[62:0], 1'b0};
              if (!diff[64]) begin
                rem_r <= diff[63:0];
                acc_r <= {acc_r[62:0], 1'b1};
              end else begin
                rem_r <= rem_sh;
                acc_r <= {acc_r[62:0], 1'b0};
              end
            end
            U_SHL:   acc_r <= {acc_r[62:0], 1'b0};
            default: acc_r <= {1'b0, acc_r[63:1]};
          endcase
        end
      end
    end
  end

  assign result = acc_r;

endmodule

[src/stack_machine_execute_unit.sv]
// Sequence: an accepted word passes S_RD1, S_RD2 and S_EXEC, then S_UNIT for mul, div
// and shifts (one place or bit per cycle in the shared unit) or S_FETCH for fetch, then
// S_WB, which drains up to three stack writes, and S_DONE, where out_valid rises;
// a result held by out_ready low stalls it further.
// Throughput: one command at a time; in_ready returns in the cycle after the result
// registers. After reset the data store is cleared word by word, in_ready low.
// Reset: synchronous active-low; stack empty, halt flag clear, data store zero.
module stack_machine_execute_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smeu_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output smeu_pkg::out_word_t out_data
);
  import smeu_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_UNIT, S_FETCH, S_WB, S_DONE
  } state_t;

  state_t         state_r, exec_nxt;
  logic [AdW:0]   clr_r;
  cmd_t           cmd_r;
  logic [63:0]    lit_r, b_r, c_r;
  logic [SpW-1:0] sp_r, sp_nxt;
  logic           halt_r, halt_nxt;
  err_t           err_r, err_nxt;
  logic [63:0]    stk [StackDepth];
  logic [63:0]    store [StoreDepth];
  logic [63:0]    stk_q, store_q, top_mem_q;
  logic [SaW-1:0] stk_ra;
  logic [AdW-1:0] store_ra;
  // pending write list: up to three stack writes
  logic [1:0]     nwr_r, nwr_nxt;
  logic [SaW-1:0] wa_r [3];
  logic [SaW-1:0] wa_nxt [3];
  logic [63:0]    wd_r [3];
  logic [63:0]    wd_nxt [3];
  logic           st_we;
  logic           ustart_r, ustart_nxt;
  uop_t           uop_r, uop_nxt;
  unit_ctl_t      uctl;
  logic           udone;
  logic [63:0]    ures;
  logic           ready_out;
  logic           fits_store;
  logic           shift_op;

  smeu_alu_unit u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(uctl), .a(b_r), .b(c_r),
    .done(udone), .result(ures)
  );

  assign uctl.start = ustart_r;
  assign uctl.op    = uop_r;

  always_ff @(posedge clk) stk_q <= stk[stk_ra];
  always_ff @(posedge clk) store_q <= store[store_ra];

  function automatic logic [SaW-1:0] ix(input logic [SpW-1:0] p, input int k);
    logic [SpW-1:0] t;
    t = p - SpW'(k);
    return t[SaW-1:0];
  endfunction

  // top of stack, sampled after the last write has landed
  always_ff @(posedge clk) top_mem_q <= stk[ix(sp_r, 1)];

  assign ready_out = !out_valid || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  // operand read addresses: c = top, b = second, third lands in stk_q (rot only)
  always_comb begin
    case (state_r)
      S_IDLE:  stk_ra = ix(sp_r, 1);
      S_RD1:   stk_ra = ix(sp_r, 2);
      default: stk_ra = ix(sp_r, 3);
    endcase
    store_ra = c_r[AdW-1:0];
  end

  assign fits_store = (c_r < 64'(StoreDepth));
  assign shift_op   = (cmd_r == C_SHL) || (cmd_r == C_SHR);

  always_comb begin
    err_nxt    = E_OK;
    sp_nxt     = sp_r;
    halt_nxt   = halt_r;
    nwr_nxt    = 2'd0;
    exec_nxt   = S_WB;
    st_we      = 1'b0;
    ustart_nxt = 1'b0;
    uop_nxt    = U_MUL;
    for (int k = 0; k < 3; k++) begin
      wa_nxt[k] = '0;
      wd_nxt[k] = '0;
    end
    if (halt_r) begin
      err_nxt = E_HALT;
    end else begin
      case (cmd_r)
        C_LIT: begin
          if (sp_r >= SpW'(StackDepth)) err_nxt = E_OVER;
          else begin
            wa_nxt[0] = ix(sp_r, 0); wd_nxt[0] = lit_r; nwr_nxt = 2'd1;
            sp_nxt = sp_r + SpW'(1);
          end
        end
        C_NOT, C_LNOT: begin
          if (sp_r < SpW'(1)) err_nxt = E_UNDER;
          else begin
            wa_nxt[0] = ix(sp_r, 1); nwr_nxt = 2'd1;
            wd_nxt[0] = (cmd_r == C_NOT) ? ~c_r : {63'd0, c_r == 64'd0};
          end
        end
        C_EXIT: halt_nxt = 1'b1;
        C_DROP: begin
          if (sp_r < SpW'(1)) err_nxt = E_UNDER;
          else sp_nxt = sp_r - SpW'(1);
        end
        C_DUP: begin
          if (sp_r < SpW'(1)) err_nxt = E_UNDER;
          else if (sp_r >= SpW'(StackDepth)) err_nxt = E_OVER;
          else begin
            wa_nxt[0] = ix(sp_r, 0); wd_nxt[0] = c_r; nwr_nxt = 2'd1;
            sp_nxt = sp_r + SpW'(1);
          end
        end
        C_SWAP: begin
          if (sp_r < SpW'(2)) err_nxt = E_UNDER;
          else begin
            wa_nxt[0] = ix(sp_r, 2); wd_nxt[0] = c_r;
            wa_nxt[1] = ix(sp_r, 1); wd_nxt[1] = b_r; nwr_nxt = 2'd2;
          end
        end
        C_OVER: begin
          if (sp_r < SpW'(2)) err_nxt = E_UNDER;
          else if (sp_r >= SpW'(StackDepth)) err_nxt = E_OVER;
          else begin
            wa_nxt[0] = ix(sp_r, 0); wd_nxt[0] = b_r; nwr_nxt = 2'd1;
            sp_nxt = sp_r + SpW'(1);
          end
        end
        C_ROT: begin
          if (sp_r < SpW'(3)) err_nxt = E_UNDER;
          else begin
            wa_nxt[0] = ix(sp_r, 3); wd_nxt[0] = b_r;
            wa_nxt[1] = ix(sp_r, 2); wd_nxt[1] = c_r;
            wa_nxt[2] = ix(sp_r, 1); wd_nxt[2] = stk_q; nwr_nxt = 2'd3;
          end
        end
        C_NIP: begin
          if (sp_r < SpW'(2)) err_nxt = E_UNDER;
          else begin
            wa_nxt[0] = ix(sp_r, 2); wd_nxt[0] = c_r; nwr_nxt = 2'd1;
            sp_nxt = sp_r - SpW'(1);
          end
        end
        C_TUCK: begin
          if (sp_r < SpW'(2)) err_nxt = E_UNDER;
          else if (sp_r >= SpW'(StackDepth)) err_nxt = E_OVER;
          else begin
            wa_nxt[0] = ix(sp_r, 2); wd_nxt[0] = c_r;
            wa_nxt[1] = ix(sp_r, 1); wd_nxt[1] = b_r;
            wa_nxt[2] = ix(sp_r, 0); wd_nxt[2] = c_r; nwr_nxt = 2'd3;
            sp_nxt = sp_r + SpW'(1);
          end
        end
        C_DROP2: begin
          if (sp_r < SpW'(2)) err_nxt = E_UNDER;
          else sp_nxt = sp_r - SpW'(2);
        end
        C_DUP2: begin
          if (sp_r < SpW'(2)) err_nxt = E_UNDER;
          else if (sp_r + SpW'(1) >= SpW'(StackDepth)) err_nxt = E_OVER;
          else begin
            wa_nxt[0] = ix(sp_r, 0); wd_nxt[0] = b_r;
            wa_nxt[1] = ix(sp_r, -1); wd_nxt[1] = c_r; nwr_nxt = 2'd2;
            sp_nxt = sp_r + SpW'(2);
          end
        end
        C_STORE: begin
          if (sp_r < SpW'(2)) err_nxt = E_UNDER;
          else if (!fits_store) err_nxt = E_ADDR;
          else begin
            st_we = 1'b1;
            sp_nxt = sp_r - SpW'(2);
          end
        end
        C_FETCH: begin
          if (sp_r < SpW'(1)) err_nxt = E_UNDER;
          else if (!fits_store) err_nxt = E_ADDR;
          else begin
            wa_nxt[0] = ix(sp_r, 1); nwr_nxt = 2'd1;
            exec_nxt = S_FETCH;
          end
        end
        default: begin
          // binary words
          if (sp_r < SpW'(2)) err_nxt = E_UNDER;
          else if (cmd_r == C_DIV && c_r == 64'd0) begin
            err_nxt = E_DIVZ; sp_nxt = sp_r - SpW'(2);
          end else if (shift_op && c_r[63]) begin
            err_nxt = E_NEGSH; sp_nxt = sp_r - SpW'(2);
          end else if (shift_op && c_r >= 64'(WordBits)) begin
            err_nxt = E_BIGSH; sp_nxt = sp_r - SpW'(2);
          end else begin
            wa_nxt[0] = ix(sp_r, 2); nwr_nxt = 2'd1; sp_nxt = sp_r - SpW'(1);
            case (cmd_r)
              C_ADD:  wd_nxt[0] = b_r + c_r;
              C_SUB:  wd_nxt[0] = b_r - c_r;
              C_AND:  wd_nxt[0] = b_r & c_r;
              C_OR:   wd_nxt[0] = b_r | c_r;
              C_XOR:  wd_nxt[0] = b_r ^ c_r;
              C_LAND: wd_nxt[0] = {63'd0, (b_r != 64'd0) && (c_r != 64'd0)};
              C_LOR:  wd_nxt[0] = {63'd0, (b_r != 64'd0) || (c_r != 64'd0)};
              C_GT:   wd_nxt[0] = {63'd0, $signed(b_r) > $signed(c_r)};
              C_LT:   wd_nxt[0] = {63'd0, $signed(b_r) < $signed(c_r)};
              C_EQ:   wd_nxt[0] = {63'd0, b_r == c_r};
              C_NE:   wd_nxt[0] = {63'd0, b_r != c_r};
              C_LE:   wd_nxt[0] = {63'd0, $signed(b_r) <= $signed(c_r)};
              C_GE:   wd_nxt[0] = {63'd0, $signed(b_r) >= $signed(c_r)};
              default: begin
                // long ops go to the shared unit; operands stay in b_r, c_r
                ustart_nxt = 1'b1;
                exec_nxt   = S_UNIT;
                case (cmd_r)
                  C_MUL:   uop_nxt = U_MUL;
                  C_DIV:   uop_nxt = U_DIV;
                  C_SHL:   uop_nxt = U_SHL;
                  default: uop_nxt = U_SHR;
                endcase
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      sp_r      <= '0;
      halt_r    <= 1'b0;
      err_r     <= E_OK;
      out_valid <= 1'b0;
      nwr_r     <= '0;
      ustart_r  <= 1'b0;
      uop_r     <= U_MUL;
    end else begin
      ustart_r <= (state_r == S_EXEC) && ustart_nxt;
      if (state_r == S_DONE && ready_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state_r)
        S_CLR: begin
          store[clr_r[AdW-1:0]] <= '0;
          clr_r <= clr_r + (AdW+1)'(1);
          if (clr_r == (AdW+1)'(StoreDepth - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd_t'(in_data.cmd);
            lit_r   <= in_data.literal;
            state_r <= S_RD1;
          end
        end
        S_RD1: begin c_r <= stk_q; state_r <= S_RD2; end
        S_RD2: begin b_r <= stk_q; state_r <= S_EXEC; end
        S_EXEC: begin
          err_r  <= err_nxt;
          sp_r   <= sp_nxt;
          halt_r <= halt_nxt;
          nwr_r  <= nwr_nxt;
          uop_r  <= uop_nxt;
          for (int k = 0; k < 3; k++) begin
            wa_r[k] <= wa_nxt[k];
            wd_r[k] <= wd_nxt[k];
          end
          if (st_we) store[c_r[AdW-1:0]] <= b_r;
          state_r <= exec_nxt;
        end
        S_UNIT: if (udone) begin wd_r[0] <= ures; state_r <= S_WB; end
        S_FETCH: begin wd_r[0] <= store_q; state_r <= S_WB; end
        S_WB: begin
          // drain writes one per cycle, last one first
          if (nwr_r != 2'd0) begin
            stk[wa_r[nwr_r - 2'd1]] <= wd_r[nwr_r - 2'd1];
            nwr_r <= nwr_r - 2'd1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold here while the previous word still waits
          if (ready_out) begin
            out_data.top_value   <= (sp_r == '0) ? 64'd0 : top_mem_q;
            out_data.stack_depth <= sp_r;
            out_data.error_code  <= err_r;
            out_data.halted      <= halt_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_idle_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready) else $error("ready during clear");
  a_sp_rng: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SpW'(StackDepth)) else $error("stack pointer out of range");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(halt_r) |-> halt_r) else $error("halt cleared");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result word changed while waiting");

endmodule
